FILE: src/tcps_pkg.sv
// Shared types and codes for the three-class priority scheduler.
package tcps_pkg;

  localparam int ID_W = 8;
  localparam int RUN_W = 8;
  localparam int NUM_CLASSES = 3;

  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_GRANT = 1'b1;

  localparam logic [1:0] CLS_URGENT = 2'd0;
  localparam logic [1:0] CLS_A = 2'd1;
  localparam logic [1:0] CLS_B = 2'd2;

  localparam logic [1:0] STAT_GRANTED = 2'd0;
  localparam logic [1:0] STAT_NONE = 2'd1;
  localparam logic [1:0] STAT_ENQUEUED = 2'd2;
  localparam logic [1:0] STAT_FULL = 2'd3;

  localparam logic [RUN_W-1:0] RUN_MAX = 8'hFF;
  localparam logic [RUN_W-1:0] MAX_RUN_RESET = 8'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage

FILE: src/tcps_if.sv
// Request and result channel interfaces of the scheduler.
interface tcps_req_if;
  import tcps_pkg::*;
  logic valid;
  logic ready;
  logic cmd;
  logic [1:0] queue_class;
  logic [ID_W-1:0] requester_id;
  modport source (output valid, cmd, queue_class, requester_id, input ready);
  modport sink (input valid, cmd, queue_class, requester_id, output ready);
endinterface

interface tcps_rsp_if;
  import tcps_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [ID_W-1:0] granted_id;
  logic [1:0] granted_class;
  logic any_waiting;
  modport source (output valid, status, granted_id, granted_class, any_waiting,
                  input ready);
  modport sink (input valid, status, granted_id, granted_class, any_waiting,
                output ready);
endinterface

FILE: src/tcps_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/tcps_ctrl.sv
// Controller state machine: sequences capture, execute and result load.
module tcps_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcps_pkg::dp_sts_t   sts,
  output tcps_pkg::ctrl_cmd_t cmd
);
  import tcps_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.capture = in_valid;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
      end
      S_LOAD: begin
        cmd.load = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

FILE: src/tcps_dp.sv
// Datapath: queue RAMs, pointers, run counter, priority choice and result register.
module tcps_dp #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tcps_pkg::RUN_W-1:0]    cfg_wdata,
  input  logic                          in_cmd,
  input  logic [1:0]                    in_class,
  input  logic [tcps_pkg::ID_W-1:0]     in_id,
  tcps_rsp_if.source                    rsp,
  input  tcps_pkg::ctrl_cmd_t           cmd,
  output tcps_pkg::dp_sts_t             sts
);
  import tcps_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = PTR_W + 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [SUM_W-1:0] SUM_DEPTH = SUM_W'(QUEUE_DEPTH);

  logic             r_cmd;
  logic [1:0]       r_class;
  logic [ID_W-1:0]  r_id;

  logic [PTR_W-1:0] head [NUM_CLASSES];
  logic [CNT_W-1:0] count [NUM_CLASSES];
  logic [PTR_W-1:0] head_next [NUM_CLASSES];
  logic [CNT_W-1:0] count_next [NUM_CLASSES];
  logic [PTR_W-1:0] tail [NUM_CLASSES];
  logic [SUM_W-1:0] tail_sum [NUM_CLASSES];
  logic [ID_W-1:0]  rd [NUM_CLASSES];
  logic             push [NUM_CLASSES];
  logic             pop [NUM_CLASSES];
  logic             nonempty [NUM_CLASSES];
  logic             full [NUM_CLASSES];

  logic [RUN_W-1:0] run;
  logic [RUN_W-1:0] run_next;
  logic [RUN_W-1:0] max_run;

  logic             sel_valid;
  logic [1:0]       sel_class;
  logic             any_next;
  logic [1:0]       status_next;

  logic             p_grant;
  logic [1:0]       p_status;
  logic [1:0]       p_class;
  logic             p_any;

  logic             out_valid;
  logic [1:0]       out_status;
  logic [ID_W-1:0]  out_id;
  logic [1:0]       out_class;
  logic             out_any;
  logic [ID_W-1:0]  sel_rd;

  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      nonempty[c] = (count[c] != '0);
      full[c] = (count[c] == CNT_FULL);
      tail_sum[c] = SUM_W'(head[c]) + SUM_W'(count[c]);
      if (tail_sum[c] >= SUM_DEPTH) begin
        tail[c] = PTR_W'(tail_sum[c] - SUM_DEPTH);
      end else begin
        tail[c] = tail_sum[c][PTR_W-1:0];
      end
    end

    sel_valid = 1'b1;
    sel_class = CLS_URGENT;
    if (nonempty[0]) begin
      sel_class = CLS_URGENT;
    end else if (nonempty[2] && (run >= max_run)) begin
      sel_class = CLS_B;
    end else if (nonempty[1]) begin
      sel_class = CLS_A;
    end else if (nonempty[2]) begin
      sel_class = CLS_B;
    end else begin
      sel_valid = 1'b0;
    end

    any_next = 1'b0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      push[c] = cmd.exec && (r_cmd == CMD_ENQUEUE) && (r_class == 2'(c)) && !full[c];
      pop[c] = cmd.exec && (r_cmd == CMD_GRANT) && sel_valid && (sel_class == 2'(c));
      if (push[c]) begin
        count_next[c] = count[c] + CNT_W'(1);
      end else if (pop[c]) begin
        count_next[c] = count[c] - CNT_W'(1);
      end else begin
        count_next[c] = count[c];
      end
      if (pop[c]) begin
        head_next[c] = (head[c] == PTR_LAST) ? '0 : head[c] + PTR_W'(1);
      end else begin
        head_next[c] = head[c];
      end
      any_next = any_next | (count_next[c] != '0);
    end

    run_next = run;
    if (pop[2]) begin
      run_next = '0;
    end else if ((pop[0] || pop[1]) && (run != RUN_MAX)) begin
      run_next = run + RUN_W'(1);
    end

    if (r_cmd == CMD_ENQUEUE) begin
      status_next = (push[0] || push[1] || push[2]) ? STAT_ENQUEUED : STAT_FULL;
    end else begin
      status_next = sel_valid ? STAT_GRANTED : STAT_NONE;
    end
  end

  for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_queue
    tcps_ram #(
      .WIDTH (ID_W),
      .DEPTH (QUEUE_DEPTH),
      .ADDR_W(PTR_W)
    ) u_ram (
      .clk  (clk),
      .we   (push[g]),
      .waddr(tail[g]),
      .wdata(r_id),
      .re   (pop[g]),
      .raddr(head[g]),
      .rdata(rd[g])
    );
  end

  always_comb begin
    case (p_class)
      CLS_URGENT: sel_rd = rd[0];
      CLS_A:      sel_rd = rd[1];
      CLS_B:      sel_rd = rd[2];
      default:    sel_rd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r_cmd <= in_cmd;
      r_class <= in_class;
      r_id <= in_id;
    end
    if (cmd.exec) begin
      p_grant <= (r_cmd == CMD_GRANT) && sel_valid;
      p_status <= status_next;
      p_class <= ((r_cmd == CMD_GRANT) && sel_valid) ? sel_class : CLS_URGENT;
      p_any <= any_next;
    end
    if (cmd.load) begin
      out_status <= p_status;
      out_id <= p_grant ? sel_rd : '0;
      out_class <= p_class;
      out_any <= p_any;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head[c] <= '0;
        count[c] <= '0;
      end
      run <= '0;
      max_run <= MAX_RUN_RESET;
      out_valid <= 1'b0;
    end else begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head[c] <= head_next[c];
        count[c] <= count_next[c];
      end
      run <= run_next;
      if (cfg_we) begin
        max_run <= cfg_wdata;
      end
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.out_free = !out_valid || rsp.ready;

  assign rsp.valid = out_valid;
  assign rsp.status = out_status;
  assign rsp.granted_id = out_id;
  assign rsp.granted_class = out_class;
  assign rsp.any_waiting = out_any;

endmodule

FILE: src/three_class_priority_scheduler.sv
// Top level of the three-class strict priority scheduler with starvation counter.
//
//   Channel  Modport  Carries
//   req      sink     cmd, queue_class, requester_id (enqueue or grant request)
//   rsp      source   status, granted_id, granted_class, any_waiting
//   cfg      write    cfg_we, cfg_wdata (max_run_before_b)
//
// Each request passes through capture, execute (queue update and queue RAM read) and
// result load; the registered queue RAM read port makes result load a step of its own.
// Reset is synchronous: queue counts, heads and the run counter clear, the run limit
// becomes 3; queue contents are left as they are and need no clearing pass.
// A result that is not taken waits in the output register while the next request is
// accepted and executed; that request then holds until the output register frees.
module three_class_priority_scheduler #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [tcps_pkg::RUN_W-1:0] cfg_wdata,
  tcps_req_if.sink                   req,
  tcps_rsp_if.source                 rsp
);
  import tcps_pkg::*;

  ctrl_cmd_t dp_cmd;
  dp_sts_t   dp_sts;
  logic      in_ready;

  assign req.ready = in_ready;

  tcps_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(req.valid),
    .in_ready(in_ready),
    .sts     (dp_sts),
    .cmd     (dp_cmd)
  );

  tcps_dp #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_cmd   (req.cmd),
    .in_class (req.queue_class),
    .in_id    (req.requester_id),
    .rsp      (rsp),
    .cmd      (dp_cmd),
    .sts      (dp_sts)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("scheduler accepted a request while one was in execution");

  a_exec_follows_capture: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.capture |=> dp_cmd.exec)
    else $error("captured request was not executed in the next cycle");

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.load |-> dp_sts.out_free)
    else $error("result loaded over an untaken result");

  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(dp_cmd.load))
    else $error("result valid rose without a result load");
`endif

endmodule

FILE: sim/tcps_grant_checker.sv
// Checker that predicts every scheduler result and compares it with the result channel.
`timescale 1ns / 100ps

module tcps_grant_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [tcps_pkg::RUN_W-1:0] cfg_wdata,
  input  logic                       req_valid,
  input  logic                       req_ready,
  input  logic                       req_cmd,
  input  logic [1:0]                 req_queue_class,
  input  logic [tcps_pkg::ID_W-1:0]  req_requester_id,
  input  logic                       rsp_valid,
  input  logic                       rsp_ready,
  input  logic [1:0]                 rsp_status,
  input  logic [tcps_pkg::ID_W-1:0]  rsp_granted_id,
  input  logic [1:0]                 rsp_granted_class,
  input  logic                       rsp_any_waiting,
  output int                         fail_count,
  output int                         results_due
);
  import tcps_pkg::*;

  typedef struct packed {
    logic [1:0]      status;
    logic [ID_W-1:0] granted_id;
    logic [1:0]      granted_class;
    logic            any_waiting;
  } sched_result_t;

  logic [ID_W-1:0]  urgent_ids[$];
  logic [ID_W-1:0]  class_a_ids[$];
  logic [ID_W-1:0]  class_b_ids[$];
  logic [RUN_W-1:0] grant_run;
  logic [RUN_W-1:0] run_limit;
  sched_result_t    due_results[$];
  int               mismatches = 0;

  function automatic sched_result_t schedule_step(input logic cmd, input logic [1:0] cls,
                                                  input logic [ID_W-1:0] id);
    sched_result_t r;
    r = '0;
    if (cmd == CMD_ENQUEUE) begin
      r.status = STAT_FULL;
      if (cls == CLS_URGENT && urgent_ids.size() < QUEUE_DEPTH) begin
        urgent_ids.push_back(id);
        r.status = STAT_ENQUEUED;
      end else if (cls == CLS_A && class_a_ids.size() < QUEUE_DEPTH) begin
        class_a_ids.push_back(id);
        r.status = STAT_ENQUEUED;
      end else if (cls == CLS_B && class_b_ids.size() < QUEUE_DEPTH) begin
        class_b_ids.push_back(id);
        r.status = STAT_ENQUEUED;
      end
    end else begin
      r.status = STAT_GRANTED;
      if (urgent_ids.size() > 0) begin
        r.granted_id = urgent_ids.pop_front();
        r.granted_class = CLS_URGENT;
        if (grant_run != RUN_MAX) grant_run = grant_run + 1'b1;
      end else if (class_b_ids.size() > 0 && grant_run >= run_limit) begin
        r.granted_id = class_b_ids.pop_front();
        r.granted_class = CLS_B;
        grant_run = '0;
      end else if (class_a_ids.size() > 0) begin
        r.granted_id = class_a_ids.pop_front();
        r.granted_class = CLS_A;
        if (grant_run != RUN_MAX) grant_run = grant_run + 1'b1;
      end else if (class_b_ids.size() > 0) begin
        r.granted_id = class_b_ids.pop_front();
        r.granted_class = CLS_B;
        grant_run = '0;
      end else begin
        r.status = STAT_NONE;
      end
    end
    r.any_waiting = (urgent_ids.size() + class_a_ids.size() + class_b_ids.size()) != 0;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin : watch
    sched_result_t want;
    if (rst) begin
      urgent_ids.delete();
      class_a_ids.delete();
      class_b_ids.delete();
      due_results.delete();
      grant_run = '0;
      run_limit = MAX_RUN_RESET;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (due_results.size() == 0) begin
          note_mismatch("unrequested result, status", -1, int'(rsp_status));
        end else begin
          want = due_results.pop_front();
          if (want.status !== rsp_status)
            note_mismatch("status", int'(want.status), int'(rsp_status));
          if (want.granted_id !== rsp_granted_id)
            note_mismatch("granted_id", int'(want.granted_id), int'(rsp_granted_id));
          if (want.granted_class !== rsp_granted_class)
            note_mismatch("granted_class", int'(want.granted_class),
                          int'(rsp_granted_class));
          if (want.any_waiting !== rsp_any_waiting)
            note_mismatch("any_waiting", int'(want.any_waiting), int'(rsp_any_waiting));
        end
      end
      if (req_valid && req_ready)
        due_results.push_back(schedule_step(req_cmd, req_queue_class, req_requester_id));
      if (cfg_we) run_limit = cfg_wdata;
    end
    fail_count <= mismatches;
    results_due <= due_results.size();
  end

endmodule

FILE: sim/tb_three_class_priority_scheduler.sv
// Top-level testbench that drives requests and configuration into the scheduler.
`timescale 1ns / 100ps

module tb_three_class_priority_scheduler;
  import tcps_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 60;
  localparam logic [1:0] CLS_UNUSED = 2'd3;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [RUN_W-1:0] cfg_wdata;
  logic             idle_on = 1'b1;
  logic             hold_request = 1'b0;
  int               fail_count;
  int               results_due;
  int               cycle_count;

  tcps_req_if req_ch();
  tcps_rsp_if rsp_ch();

  three_class_priority_scheduler #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  tcps_grant_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .req_valid        (req_ch.valid),
    .req_ready        (req_ch.ready),
    .req_cmd          (req_ch.cmd),
    .req_queue_class  (req_ch.queue_class),
    .req_requester_id (req_ch.requester_id),
    .rsp_valid        (rsp_ch.valid),
    .rsp_ready        (rsp_ch.ready),
    .rsp_status       (rsp_ch.status),
    .rsp_granted_id   (rsp_ch.granted_id),
    .rsp_granted_class(rsp_ch.granted_class),
    .rsp_any_waiting  (rsp_ch.any_waiting),
    .fail_count       (fail_count),
    .results_due      (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send(input logic cmd, input logic [1:0] cls, input logic [ID_W-1:0] id);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd <= cmd;
    req_ch.queue_class <= cls;
    req_ch.requester_id <= id;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [RUN_W-1:0] value);
    drain();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_items(input int count, input int enq_pct);
    logic       cmd;
    logic [1:0] cls;
    for (int i = 0; i < count; i++) begin
      cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQUEUE : CMD_GRANT;
      cls = ($urandom_range(0, 15) == 0) ? CLS_UNUSED : 2'($urandom_range(0, 2));
      send(cmd, cls, ID_W'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    req_ch.valid <= 1'b0;
    req_ch.cmd <= CMD_ENQUEUE;
    req_ch.queue_class <= CLS_URGENT;
    req_ch.requester_id <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(CMD_GRANT, CLS_URGENT, 8'hFF);
    send(CMD_ENQUEUE, CLS_UNUSED, 8'hFF);
    send(CMD_ENQUEUE, CLS_URGENT, 8'h00);
    send(CMD_ENQUEUE, CLS_A, 8'hFF);
    send(CMD_ENQUEUE, CLS_B, 8'h55);
    send(CMD_ENQUEUE, CLS_A, 8'hAA);
    send(CMD_ENQUEUE, CLS_B, 8'h01);
    repeat (6) send(CMD_GRANT, CLS_B, 8'h00);

    write_limit(8'd0);
    send(CMD_ENQUEUE, CLS_A, 8'h12);
    send(CMD_ENQUEUE, CLS_B, 8'h34);
    send(CMD_GRANT, CLS_A, 8'h00);
    send(CMD_GRANT, CLS_A, 8'h00);

    write_limit(8'd2);
    for (int c = 0; c < 3; c++) begin
      if (c == 1) hold_request = 1'b1;
      repeat (QUEUE_DEPTH + 2) send(CMD_ENQUEUE, 2'(c), ID_W'($urandom_range(0, 255)));
      repeat (QUEUE_DEPTH + 2) send(CMD_GRANT, 2'(c), ID_W'($urandom_range(0, 255)));
    end

    write_limit(8'd1);
    random_items(200, 50);

    write_limit(8'd255);
    repeat (3 * QUEUE_DEPTH) send(CMD_GRANT, CLS_A, 8'h00);
    repeat (260) begin
      send(CMD_ENQUEUE, CLS_A, ID_W'($urandom_range(0, 255)));
      send(CMD_GRANT, CLS_A, ID_W'($urandom_range(0, 255)));
    end
    send(CMD_ENQUEUE, CLS_B, 8'h5A);
    send(CMD_ENQUEUE, CLS_A, 8'hA5);
    send(CMD_GRANT, CLS_A, 8'h00);
    send(CMD_GRANT, CLS_A, 8'h00);

    write_limit(8'd7);
    random_items(200, 75);
    write_limit(8'd3);
    random_items(200, 35);
    write_limit(RUN_W'($urandom_range(0, 255)));
    random_items(200, 55);

    idle_on = 1'b0;
    write_limit(8'd0);
    random_items(200, 50);

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
